@@ hw/rtl/cfc_pkg.sv @@
// ----------------------------------------------------------------------------
// cfc_pkg: shared types and constants for the crc-8 frame checker
// Word formats, configuration defaults, error codes and the crc-8 byte update.
// ----------------------------------------------------------------------------
package cfc_pkg;

   localparam int unsigned MAX_HEADER = 32;
   localparam int unsigned HDR_W      = 6;
   localparam int unsigned POS_W      = 5;
   localparam int unsigned COUNT_W    = 9;

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_MSB  = 8'h80;
   localparam logic [7:0] CRC_INIT = 8'h00;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // configuration register indexes
   localparam logic [2:0] CSR_HEADER_BYTES  = 3'd0;
   localparam logic [2:0] CSR_LENGTH_POS    = 3'd1;
   localparam logic [2:0] CSR_TTL_POS       = 3'd2;
   localparam logic [2:0] CSR_PAYLOAD_LIMIT = 3'd3;
   localparam logic [2:0] CSR_TTL_CHECK     = 3'd4;

   localparam logic [HDR_W-1:0] HEADER_BYTES_RST  = 6'd8;
   localparam logic [POS_W-1:0] LENGTH_POS_RST    = 5'd0;
   localparam logic [POS_W-1:0] TTL_POS_RST       = 5'd1;
   localparam logic [7:0]       PAYLOAD_LIMIT_RST = 8'd200;
   localparam logic             TTL_CHECK_RST     = 1'b1;

   typedef enum logic [2:0] {
      ERR_NONE  = 3'd0,
      ERR_SHORT = 3'd1,
      ERR_LONG  = 3'd2,
      ERR_TTL   = 3'd3,
      ERR_CRC   = 3'd4
   } err_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic               frame_ok;
      logic [2:0]         error_code;
      logic [7:0]         crc_computed;
      logic [COUNT_W-1:0] buffer_length;
   } rsp_type;

   typedef struct packed {
      logic [HDR_W-1:0] header_bytes;
      logic [POS_W-1:0] length_field_pos;
      logic [POS_W-1:0] ttl_field_pos;
      logic [7:0]       payload_limit;
      logic             ttl_check;
   } cfg_type;

   // msb-first crc-8 update over one byte, unrolled
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/cfc_engine.sv @@
// ----------------------------------------------------------------------------
// cfc_engine: per-buffer frame state and verdict logic
// Tracks byte count, crc, captured length and ttl; forms the verdict on the
// last byte and returns the frame state to its cleared values.
// ----------------------------------------------------------------------------
module cfc_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  cfc_pkg::req_type word,
   input  cfc_pkg::cfg_type cfg,
   output cfc_pkg::rsp_type result
);
   import cfc_pkg::*;

   logic [7:0]         crc_ff, crc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         plen_ff, plen_in;
   logic               ttl_zero_ff, ttl_zero_in;
   logic               match_ff, match_in;

   logic [HDR_W-1:0]   hdr;
   logic               in_hdr;
   logic [COUNT_W-1:0] crc_end;
   logic [COUNT_W:0]   frame_need;
   logic [COUNT_W:0]   hdr_need;
   err_type            err;

   always_comb begin
      hdr = (cfg.header_bytes > HDR_W'(MAX_HEADER)) ? HDR_W'(MAX_HEADER) : cfg.header_bytes;
      in_hdr = count_ff < COUNT_W'(hdr);

      plen_in = plen_ff;
      if (in_hdr && (count_ff == COUNT_W'(cfg.length_field_pos))) begin
         plen_in = word.data_byte;
      end
      ttl_zero_in = ttl_zero_ff;
      if (in_hdr && (count_ff == COUNT_W'(cfg.ttl_field_pos))) begin
         ttl_zero_in = (word.data_byte == 8'h00);
      end

      crc_end  = COUNT_W'(hdr) + COUNT_W'(plen_in);
      crc_in   = crc_ff;
      match_in = match_ff;
      if (count_ff < crc_end) begin
         crc_in = crc8_step(crc_ff, word.data_byte);
      end else if (count_ff == crc_end) begin
         match_in = (word.data_byte == crc_ff);
      end

      count_in = (count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;

      hdr_need   = (COUNT_W+1)'(hdr) + (COUNT_W+1)'(1);
      frame_need = (COUNT_W+1)'(hdr) + (COUNT_W+1)'(plen_in) + (COUNT_W+1)'(1);

      if ({1'b0, count_in} < hdr_need) begin
         err = ERR_SHORT;
      end else if (plen_in > cfg.payload_limit) begin
         err = ERR_LONG;
      end else if ({1'b0, count_in} < frame_need) begin
         err = ERR_SHORT;
      end else if (cfg.ttl_check && ttl_zero_in) begin
         err = ERR_TTL;
      end else if (!match_in) begin
         err = ERR_CRC;
      end else begin
         err = ERR_NONE;
      end

      result.frame_ok      = (err == ERR_NONE);
      result.error_code    = err;
      result.crc_computed  = crc_in;
      result.buffer_length = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && word.last_byte)) begin
         crc_ff      <= CRC_INIT;
         count_ff    <= '0;
         plen_ff     <= '0;
         ttl_zero_ff <= 1'b1;
         match_ff    <= 1'b0;
      end else if (step) begin
         crc_ff      <= crc_in;
         count_ff    <= count_in;
         plen_ff     <= plen_in;
         ttl_zero_ff <= ttl_zero_in;
         match_ff    <= match_in;
      end
   end

endmodule

@@ hw/rtl/crc8_frame_checker.sv @@
// ----------------------------------------------------------------------------
// crc8_frame_checker: streaming crc-8 frame check, one verdict per buffer
// verdict path: input word register, then output register, to rsp_valid
// throughput: one word per cycle; a last word waits while a verdict is unread
// reset: synchronous; empties both word registers, clears the frame state and
// loads the configuration defaults
// ----------------------------------------------------------------------------
module crc8_frame_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cfc_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cfc_pkg::rsp_type rsp_word,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_wdata
);
   import cfc_pkg::*;

   cfg_type cfg_ff;
   req_type req_ff;
   logic    req_valid_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   rsp_type result;
   logic    step;

   // a non-last word never waits on the output side
   assign step      = req_valid_ff && (!req_ff.last_byte || !rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || step;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_bytes     <= HEADER_BYTES_RST;
         cfg_ff.length_field_pos <= LENGTH_POS_RST;
         cfg_ff.ttl_field_pos    <= TTL_POS_RST;
         cfg_ff.payload_limit    <= PAYLOAD_LIMIT_RST;
         cfg_ff.ttl_check        <= TTL_CHECK_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER_BYTES:  cfg_ff.header_bytes     <= csr_wdata[HDR_W-1:0];
            CSR_LENGTH_POS:    cfg_ff.length_field_pos <= csr_wdata[POS_W-1:0];
            CSR_TTL_POS:       cfg_ff.ttl_field_pos    <= csr_wdata[POS_W-1:0];
            CSR_PAYLOAD_LIMIT: cfg_ff.payload_limit    <= csr_wdata;
            CSR_TTL_CHECK:     cfg_ff.ttl_check        <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && req_ff.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && req_ff.last_byte) begin
         rsp_ff <= result;
      end
   end

   cfc_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .word   (req_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

endmodule
